/* rtl/ipid_pkg.sv */
`default_nettype none

package ipid_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_GAIN_P       = 3'd0;
	localparam logic [2:0] REG_GAIN_I       = 3'd1;
	localparam logic [2:0] REG_GAIN_D       = 3'd2;
	localparam logic [2:0] REG_OUT_MAX      = 3'd3;
	localparam logic [2:0] REG_OUT_MIN      = 3'd4;
	localparam logic [2:0] REG_PERIOD_TICKS = 3'd5;

	// Register reset values
	localparam logic [15:0] OUT_MAX_RST = 16'h7fff;
	localparam logic [15:0] OUT_MIN_RST = 16'h8000;
	localparam logic [15:0] PERIOD_RST  = 16'd1;

	// Raw sum width: three products of 16 bit gains by 16..18 bit differences
	localparam int SUM_W = 36;

	// Divide by ten: any magnitude at or above SAT_LIMIT gives a quotient beyond
	// every possible clamp bound, so only narrower magnitudes go through the
	// reciprocal multiply, which is exact below 699050.
	localparam int          MAG_W     = 19;
	localparam logic [35:0] SAT_LIMIT = 36'd327690;
	localparam logic [18:0] DIV_RECIP = 19'd419431;
	localparam int          DIV_SHIFT = 22;
	localparam logic [16:0] SAT_MAG   = 17'd32769;

	typedef struct packed {
		logic signed [15:0] measured;
		logic signed [15:0] setpoint;
	} in_t;

	typedef struct packed {
		logic               computed;
		logic signed [15:0] drive_delta;
	} out_t;

endpackage

`default_nettype wire

/* rtl/incremental_pid_step.sv */
// Incremental PID controller, one tick per item.
// Tick channel (tick_valid/tick_ready/tick) carries the measured value and the
// setpoint for one tick. Result channel (result_valid/result_ready/result)
// returns one item per tick: computed=1 with the clamped increment when the
// tick counter reached period_ticks, else computed=0 and a zero increment.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write it
// only while no tick is in flight. Unknown indexes are ignored.
// A result passes through six registers after its tick is accepted: input
// register loaded at acceptance, products, sum, magnitude, reciprocal multiply,
// clamp/output.
// Throughput: one tick per cycle without a stall, set by the six-stage pipeline;
// the error history and tick counter update at acceptance, so ticks follow back to back.
// Each stage holds while the one after it is full and stalled, so a stall on
// result_ready fills the empty stages before tick_ready drops.
// Reset clears the gains, sets the clamp to the full 16 bit range, the period
// to one, and clears the error history, tick counter and all stage valids.
`default_nettype none

module incremental_pid_step (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tick_valid,
	output logic                tick_ready,
	input  wire ipid_pkg::in_t  tick,
	output logic                result_valid,
	input  wire logic           result_ready,
	output ipid_pkg::out_t      result,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [15:0]    cfg_wdata
);

	// Configuration registers
	logic signed [15:0] gain_p_q, gain_i_q, gain_d_q, out_max_q, out_min_q;
	logic [15:0]        period_q;

	// Loop state
	logic signed [15:0] last_err_q, older_err_q;
	logic [15:0]        tick_cnt_q;

	// Stage valids and readies
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_out_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;
	logic accept;

	// Stage payloads
	logic               fire_s1, fire_s2, fire_s3, fire_s4, fire_s5;
	logic signed [15:0] e_s1, e1_s1, e2_s1;
	logic signed [32:0] pp_s2;
	logic signed [31:0] pi_s2;
	logic signed [33:0] pd_s2;
	logic signed [ipid_pkg::SUM_W-1:0] sum_s3;
	logic                      neg_s4, big_s4, neg_s5, big_s5;
	logic [ipid_pkg::MAG_W-1:0] mag_s4;
	logic [15:0]               qmag_s5;

	// Combinational intermediates
	logic [15:0]        tick_nxt;
	logic               fire_now;
	logic signed [15:0] err_now;
	logic signed [16:0] d1;
	logic signed [17:0] d2;
	logic [ipid_pkg::SUM_W-1:0] abs_sum;
	logic [2*ipid_pkg::MAG_W-1:0] recip_prod;
	logic signed [16:0] q_mag17, q_val, max17, min17;
	logic signed [15:0] clamped;

	// Pipeline handshake: a stage loads when it is empty or its successor loads
	assign rdy_out    = !v_out_q || result_ready;
	assign rdy_s5     = !v_s5 || rdy_out;
	assign rdy_s4     = !v_s4 || rdy_s5;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign tick_ready = rdy_s1;
	assign accept     = tick_valid && tick_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			out_max_q <= ipid_pkg::OUT_MAX_RST;
			out_min_q <= ipid_pkg::OUT_MIN_RST;
			period_q  <= ipid_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ipid_pkg::REG_GAIN_P:       gain_p_q  <= cfg_wdata;
				ipid_pkg::REG_GAIN_I:       gain_i_q  <= cfg_wdata;
				ipid_pkg::REG_GAIN_D:       gain_d_q  <= cfg_wdata;
				ipid_pkg::REG_OUT_MAX:      out_max_q <= cfg_wdata;
				ipid_pkg::REG_OUT_MIN:      out_min_q <= cfg_wdata;
				ipid_pkg::REG_PERIOD_TICKS: period_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance the tick counter and form the error at acceptance
	always_comb begin
		tick_nxt = tick_cnt_q + 16'd1;
		fire_now = (tick_nxt >= period_q);
		err_now  = tick.measured - tick.setpoint;
	end

	// Update the counter on each accepted item, the error history on each firing one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q  <= '0;
			last_err_q  <= '0;
			older_err_q <= '0;
		end else if (accept) begin
			tick_cnt_q <= fire_now ? 16'd0 : tick_nxt;
			if (fire_now) begin
				older_err_q <= last_err_q;
				last_err_q  <= err_now;
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1    <= tick_valid;
			if (rdy_s2)  v_s2    <= v_s1;
			if (rdy_s3)  v_s3    <= v_s2;
			if (rdy_s4)  v_s4    <= v_s3;
			if (rdy_s5)  v_s5    <= v_s4;
			if (rdy_out) v_out_q <= v_s5;
		end
	end

	// Differences for the proportional and derivative terms
	always_comb begin
		d1 = {e_s1[15], e_s1} - {e1_s1[15], e1_s1};
		d2 = {{2{e_s1[15]}}, e_s1} - {e1_s1[15], e1_s1, 1'b0} + {{2{e2_s1[15]}}, e2_s1};
	end

	// Magnitude of the raw sum
	always_comb begin
		abs_sum = sum_s3[ipid_pkg::SUM_W-1] ? (~sum_s3 + 1'b1) : sum_s3;
	end

	// Divide the magnitude by ten
	always_comb begin
		recip_prod = {{ipid_pkg::MAG_W{1'b0}}, mag_s4}
			* {{ipid_pkg::MAG_W{1'b0}}, ipid_pkg::DIV_RECIP};
	end

	// Restore the sign and clamp
	always_comb begin
		q_mag17 = big_s5 ? ipid_pkg::SAT_MAG : {1'b0, qmag_s5};
		q_val   = neg_s5 ? -q_mag17 : q_mag17;
		max17   = {out_max_q[15], out_max_q};
		min17   = {out_min_q[15], out_min_q};
		if (q_val >= max17) begin
			clamped = out_max_q;
		end else if (q_val <= min17) begin
			clamped = out_min_q;
		end else begin
			clamped = q_val[15:0];
		end
	end

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		// Input register: error and history snapshot
		if (rdy_s1) begin
			fire_s1 <= fire_now;
			e_s1    <= err_now;
			e1_s1   <= last_err_q;
			e2_s1   <= older_err_q;
		end
		// Three gain products
		if (rdy_s2) begin
			fire_s2 <= fire_s1;
			pp_s2   <= {{17{gain_p_q[15]}}, gain_p_q} * {{16{d1[16]}}, d1};
			pi_s2   <= {{16{gain_i_q[15]}}, gain_i_q} * {{16{e_s1[15]}}, e_s1};
			pd_s2   <= {{18{gain_d_q[15]}}, gain_d_q} * {{16{d2[17]}}, d2};
		end
		// Raw sum at full width
		if (rdy_s3) begin
			fire_s3 <= fire_s2;
			sum_s3  <= {{3{pp_s2[32]}}, pp_s2} + {{4{pi_s2[31]}}, pi_s2}
				+ {{2{pd_s2[33]}}, pd_s2};
		end
		// Sign, saturation flag and narrow magnitude
		if (rdy_s4) begin
			fire_s4 <= fire_s3;
			neg_s4  <= sum_s3[ipid_pkg::SUM_W-1];
			big_s4  <= (abs_sum >= ipid_pkg::SAT_LIMIT);
			mag_s4  <= abs_sum[ipid_pkg::MAG_W-1:0];
		end
		// Quotient magnitude
		if (rdy_s5) begin
			fire_s5 <= fire_s4;
			neg_s5  <= neg_s4;
			big_s5  <= big_s4;
			qmag_s5 <= recip_prod[ipid_pkg::DIV_SHIFT+15:ipid_pkg::DIV_SHIFT];
		end
		// Output register
		if (rdy_out) begin
			result.computed    <= fire_s5;
			result.drive_delta <= fire_s5 ? clamped : 16'sd0;
		end
	end

	assign result_valid = v_out_q;

endmodule

`default_nettype wire
